// ===== rtl/rgbcc_pkg.sv =====
// shared types and constants for the rgb lamp color wheel and command controller
// no dependencies
package rgbcc_pkg;

   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_DIAL = 2'd1;
   localparam logic [1:0] FUNC_RF   = 2'd2;
   localparam logic [1:0] FUNC_KEY  = 2'd3;

   localparam logic [1:0] CSR_STEP  = 2'd0;
   localparam logic [1:0] CSR_UPPER = 2'd1;
   localparam logic [1:0] CSR_LOWER = 2'd2;
   localparam logic [1:0] CSR_HOLD  = 2'd3;

   localparam logic [3:0] OP_TEST0  = 4'd0;
   localparam logic [3:0] OP_TEST1  = 4'd1;
   localparam logic [3:0] OP_VOLUME = 4'd2;
   localparam logic [3:0] OP_MODE   = 4'd3;
   localparam logic [3:0] OP_COLOR  = 4'd4;
   localparam logic [3:0] OP_DUTY   = 4'd5;

   localparam logic [1:0] MODE_NIGHT = 2'd1;
   localparam logic [1:0] MODE_COLOR = 2'd2;

   localparam logic [14:0] PERIOD_DIVIDEND = 15'h6400;
   localparam logic [6:0]  DUTY_RESET      = 7'd100;
   localparam logic [14:0] PERIOD_RESET    = 15'd256;
   localparam int          DIV_STEPS       = 15;

   // controller to datapath
   typedef struct packed {
      logic apply;      // one-cycle strobe that runs the item update
      logic div_start;  // load the divider
      logic div_step;   // one quotient bit
      logic div_done;   // write period
      logic rsp_load;   // capture result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
   } sts_type;

endpackage

// ===== rtl/rgbcc_ctrl.sv =====
// controller state machine: sequences apply, divide and result transfer
// depends on rgbcc_pkg
module rgbcc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  rgbcc_pkg::sts_type sts,
   output rgbcc_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_APPLY = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       vld_ff, vld_in;

   // a new item only starts when the result register is free or draining
   assign req_tready = !reset && (state_ff == ST_IDLE) && (!vld_ff || rsp_tready);
   assign rsp_tvalid = vld_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      vld_in   = vld_ff && !rsp_tready;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               cnt_in   = 4'(rgbcc_pkg::DIV_STEPS - 1);
               state_in = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               cmd.div_done = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.rsp_load = 1'b1;
            vld_in   = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_tvalid) else $error("result not shown");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("accept while busy");

endmodule

// ===== rtl/rgbcc_datapath.sv =====
// datapath: lamp state, item update, restoring divider and result register
// depends on rgbcc_pkg
module rgbcc_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_addr,
   input  logic [7:0]         csr_wdata,
   input  logic               req_accept,
   input  logic [1:0]         in_func,
   input  logic               in_cw,
   input  logic [7:0]         in_head,
   input  logic [7:0]         in_a1,
   input  logic [7:0]         in_a2,
   input  logic [7:0]         in_a3,
   input  rgbcc_pkg::cmd_type cmd,
   output rgbcc_pkg::sts_type sts,
   output logic [55:0]        rsp_data
);

   logic [7:0] step_ff, upper_ff, lower_ff, holdc_ff;
   logic [7:0] tr_ff, tg_ff, tb_ff, cr_ff, cg_ff, cb_ff;
   logic [2:0] ph_ff;
   logic [7:0] hc_ff;
   logic [1:0] mode_ff, vol_ff;
   logic [6:0] duty_ff, cduty_ff, nduty_ff;
   logic [14:0] per_ff;
   logic [7:0] hdr_ff;
   // captured item
   logic [1:0] f_ff; logic cw_ff; logic [7:0] h_ff, a1_ff, a2_ff, a3_ff;
   logic rel_ff, chm_ff, vup_ff;
   // divider
   logic [14:0] q_ff; logic [6:0] rem_ff; logic [6:0] dv_ff;

   function automatic logic [7:0] rise(input logic [7:0] t, input logic [7:0] s,
                                       input logic [7:0] up);
      logic [8:0] sum;
      sum = {1'b0, t} + {1'b0, s};
      if (t < up) return sum[8] ? 8'hff : sum[7:0];
      return 8'hff;
   endfunction

   function automatic logic [7:0] fall(input logic [7:0] t, input logic [7:0] s,
                                       input logic [7:0] lo);
      if (t > lo) return (t > s) ? t - s : 8'd0;
      return 8'd0;
   endfunction

   function automatic logic [7:0] fade(input logic [7:0] c, input logic [7:0] t);
      if (c < t) return c + 8'd1;
      if (c > t) return c - 8'd1;
      return c;
   endfunction

   // item update, evaluated combinationally while cmd.apply is high
   logic [7:0] tr_n, tg_n, tb_n, cr_n, cg_n, cb_n, hc_n, hdr_n;
   logic [2:0] ph_n; logic [1:0] mode_n, vol_n;
   logic [6:0] duty_n, cduty_n, nduty_n;
   logic rel_n, chm_n, vup_n;
   logic [8:0] hc_inc;
   logic test_ok, guard;

   always_comb begin
      tr_n = tr_ff; tg_n = tg_ff; tb_n = tb_ff;
      cr_n = cr_ff; cg_n = cg_ff; cb_n = cb_ff;
      hc_n = hc_ff; ph_n = ph_ff; mode_n = mode_ff; vol_n = vol_ff;
      duty_n = duty_ff; cduty_n = cduty_ff; nduty_n = nduty_ff; hdr_n = hdr_ff;
      rel_n = 1'b0; chm_n = 1'b0; vup_n = 1'b0;
      hc_inc = {1'b0, hc_ff} + 9'd1;
      test_ok = (a1_ff == 8'h00 && a2_ff == 8'h00 && a3_ff == 8'h00) ||
                (a1_ff == 8'hff && a2_ff == 8'h00 && a3_ff == 8'hff);
      guard = (a2_ff == 8'h00) && (a3_ff == 8'h00 || a3_ff == 8'hff);
      unique case (f_ff)
         rgbcc_pkg::FUNC_TICK: begin
            cr_n = fade(cr_ff, tr_ff); cg_n = fade(cg_ff, tg_ff); cb_n = fade(cb_ff, tb_ff);
         end
         rgbcc_pkg::FUNC_DIAL: begin
            unique case (ph_ff)
               3'd0: if (cw_ff) begin
                  tr_n = rise(tr_ff, step_ff, upper_ff); tb_n = fall(tb_ff, step_ff, lower_ff);
                  if (cr_ff == 8'hff && cb_ff == 8'h00) begin ph_n = 3'd1; hc_n = '0; end
               end else begin
                  tr_n = fall(tr_ff, step_ff, lower_ff); tb_n = rise(tb_ff, step_ff, upper_ff);
                  if (cr_ff == 8'h00 && cb_ff == 8'hff) begin ph_n = 3'd5; hc_n = '0; end
               end
               3'd2: if (cw_ff) begin
                  tg_n = rise(tg_ff, step_ff, upper_ff); tr_n = fall(tr_ff, step_ff, lower_ff);
                  if (cg_ff == 8'hff && cr_ff == 8'h00) begin ph_n = 3'd3; hc_n = '0; end
               end else begin
                  tg_n = fall(tg_ff, step_ff, lower_ff); tr_n = rise(tr_ff, step_ff, upper_ff);
                  if (cg_ff == 8'h00 && cr_ff == 8'hff) begin ph_n = 3'd1; hc_n = '0; end
               end
               3'd4: if (cw_ff) begin
                  tb_n = rise(tb_ff, step_ff, upper_ff); tg_n = fall(tg_ff, step_ff, lower_ff);
                  if (cb_ff == 8'hff && cg_ff == 8'h00) begin ph_n = 3'd5; hc_n = '0; end
               end else begin
                  tb_n = fall(tb_ff, step_ff, lower_ff); tg_n = rise(tg_ff, step_ff, upper_ff);
                  if (cb_ff == 8'h00 && cg_ff == 8'hff) begin ph_n = 3'd3; hc_n = '0; end
               end
               3'd1, 3'd3, 3'd5: begin
                  hc_n = hc_inc[7:0];
                  if (hc_inc[7:0] >= holdc_ff) begin
                     hc_n = '0;
                     // hold phases step one either way, wrapping over six
                     if (cw_ff) ph_n = (ph_ff == 3'd5) ? 3'd0 : ph_ff + 3'd1;
                     else ph_n = ph_ff - 3'd1;
                  end
               end
               default: ;
            endcase
         end
         rgbcc_pkg::FUNC_KEY: chm_n = 1'b1;
         rgbcc_pkg::FUNC_RF: begin
            if (hdr_ff != {4'd0, h_ff[7:4]}) begin
               hdr_n = {4'd0, h_ff[7:4]};
               unique case (h_ff[3:0])
                  rgbcc_pkg::OP_TEST0, rgbcc_pkg::OP_TEST1: chm_n = test_ok;
                  rgbcc_pkg::OP_VOLUME:
                     if (guard && a1_ff >= 8'd1 && a1_ff <= 8'd3) begin
                        vol_n = 2'(8'd3 - a1_ff); vup_n = 1'b1;
                     end
                  rgbcc_pkg::OP_MODE:
                     if (guard && a1_ff <= 8'd1) begin
                        if (a1_ff == 8'd0) begin
                           mode_n = rgbcc_pkg::MODE_COLOR; duty_n = cduty_ff;
                        end else begin
                           mode_n = rgbcc_pkg::MODE_NIGHT; duty_n = nduty_ff;
                        end
                        rel_n = (duty_n != duty_ff);
                     end
                  rgbcc_pkg::OP_COLOR: begin
                     mode_n = rgbcc_pkg::MODE_COLOR;
                     tr_n = a1_ff; tg_n = a2_ff; tb_n = a3_ff;
                  end
                  rgbcc_pkg::OP_DUTY:
                     if (guard && a1_ff <= 8'd100) begin
                        duty_n = a1_ff[6:0];
                        rel_n = (duty_n != duty_ff);
                        if (mode_ff == rgbcc_pkg::MODE_COLOR) cduty_n = duty_n;
                        else nduty_n = duty_n;
                     end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   assign sts.need_div = rel_n && (duty_n != 7'd0);

   // restoring divide of the fixed dividend, one quotient bit per cycle
   logic [7:0] trial;
   assign trial = {rem_ff, q_ff[14]} - {1'b0, dv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 8'd5; upper_ff <= 8'd250; lower_ff <= 8'd5; holdc_ff <= 8'd10;
         tr_ff <= '0; tg_ff <= '0; tb_ff <= '0; cr_ff <= '0; cg_ff <= '0; cb_ff <= '0;
         ph_ff <= '0; hc_ff <= '0; mode_ff <= rgbcc_pkg::MODE_COLOR; vol_ff <= '0;
         duty_ff <= rgbcc_pkg::DUTY_RESET; cduty_ff <= rgbcc_pkg::DUTY_RESET;
         nduty_ff <= rgbcc_pkg::DUTY_RESET; per_ff <= rgbcc_pkg::PERIOD_RESET;
         hdr_ff <= 8'hff; rel_ff <= 1'b0; chm_ff <= 1'b0; vup_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               rgbcc_pkg::CSR_STEP:  step_ff  <= csr_wdata;
               rgbcc_pkg::CSR_UPPER: upper_ff <= csr_wdata;
               rgbcc_pkg::CSR_LOWER: lower_ff <= csr_wdata;
               rgbcc_pkg::CSR_HOLD:  holdc_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.apply) begin
            tr_ff <= tr_n; tg_ff <= tg_n; tb_ff <= tb_n;
            cr_ff <= cr_n; cg_ff <= cg_n; cb_ff <= cb_n;
            ph_ff <= ph_n; hc_ff <= hc_n; mode_ff <= mode_n; vol_ff <= vol_n;
            duty_ff <= duty_n; cduty_ff <= cduty_n; nduty_ff <= nduty_n; hdr_ff <= hdr_n;
            rel_ff <= rel_n; chm_ff <= chm_n; vup_ff <= vup_n;
            if (rel_n && duty_n == 7'd0) per_ff <= '0;
         end
         if (cmd.div_done) per_ff <= trial[7] ? {q_ff[13:0], 1'b0} : {q_ff[13:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         f_ff <= in_func; cw_ff <= in_cw; h_ff <= in_head;
         a1_ff <= in_a1; a2_ff <= in_a2; a3_ff <= in_a3;
      end
      if (cmd.div_start) begin
         q_ff <= rgbcc_pkg::PERIOD_DIVIDEND; rem_ff <= '0; dv_ff <= duty_n;
      end else if (cmd.div_step && !cmd.div_done) begin
         if (trial[7]) begin
            rem_ff <= {rem_ff[5:0], q_ff[14]}; q_ff <= {q_ff[13:0], 1'b0};
         end else begin
            rem_ff <= trial[6:0]; q_ff <= {q_ff[13:0], 1'b1};
         end
      end
      if (cmd.rsp_load)
         rsp_data <= {3'd0, vup_ff, vol_ff, chm_ff, mode_ff, rel_ff, per_ff, duty_ff,
                      cb_ff, cg_ff, cr_ff};
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (duty_n != 7'd0)) else $error("divide by zero");
   a_period_rule: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load && duty_ff == 7'd0 |-> per_ff == 15'd0) else $error("period mismatch");
   a_apply_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> !cmd.div_step && !cmd.rsp_load) else $error("command overlap");

endmodule

// ===== rtl/rgb_color_wheel_and_command_controller.sv =====
// top level of the rgb lamp color wheel and command controller
// depends on rgbcc_pkg, rgbcc_ctrl and rgbcc_datapath
//
// usage:
//   req_* takes one item per transfer: fade tick, dial step, rf frame or key press.
//   rsp_* returns exactly one result per item: levels, duty, period and flags.
//   the user writes color_step (0), color_upper (1), color_lower (2), hold_count (3)
//   over csr_* only while the block is idle; the block does not enforce this. writes
//   take effect on the next clock edge.
// sequencing:
//   an accepted item runs the apply state, then the done state loads the result
//   register behind rsp_tvalid; a duty change to a nonzero value puts the divide state
//   between them, where the period 25600/duty comes from a restoring divider that
//   retires one quotient bit per cycle. one item is processed at a time.
// reset (synchronous, active high) restores the documented power-on state;
// req_tready is low while reset is high.
// when the receiver stalls the result holds in the output register; a new item
// is accepted in the cycle the held result transfers.
module rgb_color_wheel_and_command_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // dial_clockwise, rf_head, rf_arg1, rf_arg2, rf_arg3
   input  logic [1:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red, green, blue, duty_percent, timer_period, period_reload, lamp_mode,
   // play_chime, volume_level, volume_update
   output logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   rgbcc_pkg::cmd_type cmd;
   rgbcc_pkg::sts_type sts;

   rgbcc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .cmd(cmd)
   );

   rgbcc_datapath u_dp (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_accept(req_tvalid && req_tready),
      .in_func(req_tuser), .in_cw(req_tdata[0]),
      .in_head(req_tdata[8:1]), .in_a1(req_tdata[16:9]),
      .in_a2(req_tdata[24:17]), .in_a3(req_tdata[32:25]),
      .cmd(cmd), .sts(sts), .rsp_data(rsp_tdata)
   );

endmodule

// ===== sim/tb_rgb_color_wheel_and_command_controller.sv =====
// testbench for the rgb lamp color wheel and command controller
// drives fade ticks, dial steps, rf frames and key presses over req_*, checks rsp_* against
// an in-bench lamp predictor; depends on rgbcc_pkg and rgb_color_wheel_and_command_controller
module tb_rgb_color_wheel_and_command_controller;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [1:0] func;
      logic       cw;
      logic [7:0] head;
      logic [7:0] arg1;
      logic [7:0] arg2;
      logic [7:0] arg3;
   } lamp_item_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [6:0]  duty;
      logic [14:0] period;
      logic        reload;
      logic [1:0]  mode;
      logic        chime;
      logic [1:0]  volume;
      logic        vol_upd;
   } lamp_result_type;

   typedef struct packed {
      lamp_item_type   item;
      logic            known;
      lamp_result_type result;
   } lamp_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [7:0]  csr_wdata = '0;

   rgb_color_wheel_and_command_controller dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the lamp state
   logic [7:0]  lp_step, lp_upper, lp_lower, lp_hold;
   logic [7:0]  lp_tgt_r, lp_tgt_g, lp_tgt_b, lp_cur_r, lp_cur_g, lp_cur_b;
   logic [2:0]  lp_phase;
   logic [7:0]  lp_hold_cnt;
   logic [1:0]  lp_mode, lp_volume;
   logic [6:0]  lp_duty, lp_color_duty, lp_night_duty;
   logic [14:0] lp_period;
   logic [7:0]  lp_last_hdr;

   lamp_result_type lamp_expected[$];
   lamp_row_type    known_rows[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   logic pressure_req = 1'b0;
   logic pressure_done = 1'b0;
   int  hold_left = 0;

   function automatic logic [7:0] level_rise(input logic [7:0] t);
      int s;
      if (t < lp_upper) begin
         s = int'(t) + int'(lp_step);
         return (s > 255) ? 8'd255 : s[7:0];
      end
      return 8'd255;
   endfunction

   function automatic logic [7:0] level_fall(input logic [7:0] t);
      if (t > lp_lower) return (t > lp_step) ? t - lp_step : 8'd0;
      return 8'd0;
   endfunction

   function automatic logic [7:0] fade_toward(input logic [7:0] c, input logic [7:0] t);
      if (c < t) return c + 8'd1;
      if (c > t) return c - 8'd1;
      return c;
   endfunction

   function automatic logic change_duty(input logic [6:0] d);
      if (lp_duty == d) return 1'b0;
      lp_duty = d;
      lp_period = (d != 7'd0) ? 15'(int'(rgbcc_pkg::PERIOD_DIVIDEND) / int'(d)) : 15'd0;
      return 1'b1;
   endfunction

   function automatic void hold_advance(input logic cw, input logic [2:0] nxt_cw,
                                        input logic [2:0] nxt_acw);
      lp_hold_cnt = lp_hold_cnt + 8'd1;
      if (lp_hold_cnt >= lp_hold) begin
         lp_hold_cnt = 8'd0;
         lp_phase = cw ? nxt_cw : nxt_acw;
      end
   endfunction

   function automatic void wheel_dial(input logic cw);
      unique case (lp_phase)
         3'd0: begin
            if (cw) begin
               lp_tgt_r = level_rise(lp_tgt_r); lp_tgt_b = level_fall(lp_tgt_b);
               if (lp_cur_r == 8'd255 && lp_cur_b == 8'd0) begin
                  lp_phase = 3'd1; lp_hold_cnt = 8'd0;
               end
            end else begin
               lp_tgt_r = level_fall(lp_tgt_r); lp_tgt_b = level_rise(lp_tgt_b);
               if (lp_cur_r == 8'd0 && lp_cur_b == 8'd255) begin
                  lp_phase = 3'd5; lp_hold_cnt = 8'd0;
               end
            end
         end
         3'd1: hold_advance(cw, 3'd2, 3'd0);
         3'd2: begin
            if (cw) begin
               lp_tgt_g = level_rise(lp_tgt_g); lp_tgt_r = level_fall(lp_tgt_r);
               if (lp_cur_g == 8'd255 && lp_cur_r == 8'd0) begin
                  lp_phase = 3'd3; lp_hold_cnt = 8'd0;
               end
            end else begin
               lp_tgt_g = level_fall(lp_tgt_g); lp_tgt_r = level_rise(lp_tgt_r);
               if (lp_cur_g == 8'd0 && lp_cur_r == 8'd255) begin
                  lp_phase = 3'd1; lp_hold_cnt = 8'd0;
               end
            end
         end
         3'd3: hold_advance(cw, 3'd4, 3'd2);
         3'd4: begin
            if (cw) begin
               lp_tgt_b = level_rise(lp_tgt_b); lp_tgt_g = level_fall(lp_tgt_g);
               if (lp_cur_b == 8'd255 && lp_cur_g == 8'd0) begin
                  lp_phase = 3'd5; lp_hold_cnt = 8'd0;
               end
            end else begin
               lp_tgt_b = level_fall(lp_tgt_b); lp_tgt_g = level_rise(lp_tgt_g);
               if (lp_cur_b == 8'd0 && lp_cur_g == 8'd255) begin
                  lp_phase = 3'd3; lp_hold_cnt = 8'd0;
               end
            end
         end
         3'd5: hold_advance(cw, 3'd0, 3'd4);
         default: ;
      endcase
   endfunction

   function automatic lamp_result_type lamp_predict(input lamp_item_type it);
      lamp_result_type r;
      logic test_ok, guard;
      r = '0;
      unique case (it.func)
         rgbcc_pkg::FUNC_TICK: begin
            lp_cur_r = fade_toward(lp_cur_r, lp_tgt_r);
            lp_cur_g = fade_toward(lp_cur_g, lp_tgt_g);
            lp_cur_b = fade_toward(lp_cur_b, lp_tgt_b);
         end
         rgbcc_pkg::FUNC_DIAL: wheel_dial(it.cw);
         rgbcc_pkg::FUNC_KEY: r.chime = 1'b1;
         rgbcc_pkg::FUNC_RF: begin
            if (lp_last_hdr != {4'd0, it.head[7:4]}) begin
               test_ok = (it.arg1 == 8'h00 && it.arg2 == 8'h00 && it.arg3 == 8'h00) ||
                         (it.arg1 == 8'hFF && it.arg2 == 8'h00 && it.arg3 == 8'hFF);
               guard = it.arg2 == 8'h00 && (it.arg3 == 8'h00 || it.arg3 == 8'hFF);
               lp_last_hdr = {4'd0, it.head[7:4]};
               unique case (it.head[3:0])
                  rgbcc_pkg::OP_TEST0, rgbcc_pkg::OP_TEST1: if (test_ok) r.chime = 1'b1;
                  rgbcc_pkg::OP_VOLUME: if (guard && it.arg1 >= 8'd1 && it.arg1 <= 8'd3) begin
                     lp_volume = 2'(8'd3 - it.arg1);
                     r.vol_upd = 1'b1;
                  end
                  rgbcc_pkg::OP_MODE: if (guard && it.arg1 <= 8'd1) begin
                     if (it.arg1 == 8'd0) begin
                        lp_mode = rgbcc_pkg::MODE_COLOR;
                        r.reload = change_duty(lp_color_duty);
                     end else begin
                        lp_mode = rgbcc_pkg::MODE_NIGHT;
                        r.reload = change_duty(lp_night_duty);
                     end
                  end
                  rgbcc_pkg::OP_COLOR: begin
                     lp_mode = rgbcc_pkg::MODE_COLOR;
                     lp_tgt_r = it.arg1; lp_tgt_g = it.arg2; lp_tgt_b = it.arg3;
                  end
                  rgbcc_pkg::OP_DUTY: if (guard && it.arg1 <= 8'd100) begin
                     r.reload = change_duty(it.arg1[6:0]);
                     if (lp_mode == rgbcc_pkg::MODE_COLOR) lp_color_duty = lp_duty;
                     else lp_night_duty = lp_duty;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      r.red = lp_cur_r; r.green = lp_cur_g; r.blue = lp_cur_b;
      r.duty = lp_duty; r.period = lp_period; r.mode = lp_mode; r.volume = lp_volume;
      return r;
   endfunction

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // request transfers feed the predictor, result transfers are checked
   always @(posedge clock) begin
      lamp_item_type   it;
      lamp_result_type pr, ex, ac;
      lamp_row_type    row;
      if (!reset && req_tvalid && req_tready) begin
         it.cw = req_tdata[0]; it.head = req_tdata[8:1]; it.arg1 = req_tdata[16:9];
         it.arg2 = req_tdata[24:17]; it.arg3 = req_tdata[32:25]; it.func = req_tuser;
         pr = lamp_predict(it);
         row = known_rows.pop_front();
         lamp_expected.push_back(row.known ? row.result : pr);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (lamp_expected.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
         end else begin
            ex = lamp_expected.pop_front();
            ac.red = rsp_tdata[7:0]; ac.green = rsp_tdata[15:8]; ac.blue = rsp_tdata[23:16];
            ac.duty = rsp_tdata[30:24]; ac.period = rsp_tdata[45:31];
            ac.reload = rsp_tdata[46]; ac.mode = rsp_tdata[48:47];
            ac.chime = rsp_tdata[49]; ac.volume = rsp_tdata[51:50];
            ac.vol_upd = rsp_tdata[52];
            check_field("red_level", int'(ex.red), int'(ac.red));
            check_field("green_level", int'(ex.green), int'(ac.green));
            check_field("blue_level", int'(ex.blue), int'(ac.blue));
            check_field("duty_percent", int'(ex.duty), int'(ac.duty));
            check_field("timer_period", int'(ex.period), int'(ac.period));
            check_field("period_reload", int'(ex.reload), int'(ac.reload));
            check_field("lamp_mode", int'(ex.mode), int'(ac.mode));
            check_field("play_chime", int'(ex.chime), int'(ac.chime));
            check_field("volume_level", int'(ex.volume), int'(ac.volume));
            check_field("volume_update", int'(ex.vol_upd), int'(ac.vol_upd));
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (pressure_req && !pressure_done) begin
         hold_left <= 300;
         pressure_done <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic drive_item(input lamp_item_type it, input logic known,
                             input lamp_result_type kr);
      lamp_row_type row;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      row.item = it; row.known = known; row.result = kr;
      known_rows.push_back(row);
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, it.arg3, it.arg2, it.arg1, it.head, it.cw};
      req_tuser <= it.func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send(input lamp_item_type it);
      drive_item(it, 1'b0, '0);
   endtask

   // csr_we drops after each write and the bench idles before returning, one update per edge
   task automatic csr_write(input logic [1:0] addr, input logic [7:0] val);
      csr_we <= 1'b1; csr_addr <= addr; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      unique case (addr)
         rgbcc_pkg::CSR_STEP:  lp_step = val;
         rgbcc_pkg::CSR_UPPER: lp_upper = val;
         rgbcc_pkg::CSR_LOWER: lp_lower = val;
         rgbcc_pkg::CSR_HOLD:  lp_hold = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (lamp_expected.size() != 0 || known_rows.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   function automatic lamp_item_type make_item(input logic [1:0] f, input logic cw,
                                               input logic [7:0] h, input logic [7:0] a1,
                                               input logic [7:0] a2, input logic [7:0] a3);
      lamp_item_type it;
      it.func = f; it.cw = cw; it.head = h; it.arg1 = a1; it.arg2 = a2; it.arg3 = a3;
      return it;
   endfunction

   function automatic lamp_item_type random_item;
      lamp_item_type it;
      int k;
      logic [3:0] hdr, op;
      it.cw = 1'($urandom_range(1));
      it.arg1 = 8'($urandom); it.arg2 = 8'($urandom); it.arg3 = 8'($urandom);
      it.head = 8'($urandom);
      k = int'($urandom_range(99));
      if (k < 45) it.func = rgbcc_pkg::FUNC_TICK;
      else if (k < 75) it.func = rgbcc_pkg::FUNC_DIAL;
      else if (k < 95) it.func = rgbcc_pkg::FUNC_RF;
      else it.func = rgbcc_pkg::FUNC_KEY;
      if (it.func == rgbcc_pkg::FUNC_RF) begin
         hdr = 4'($urandom);
         if ($urandom_range(99) < 85) begin
            while ({4'd0, hdr} == lp_last_hdr) hdr = 4'($urandom);
         end else if (lp_last_hdr <= 8'd15) begin
            hdr = lp_last_hdr[3:0];
         end
         op = ($urandom_range(99) < 85) ? 4'($urandom_range(5)) : 4'($urandom);
         it.head = {hdr, op};
         if ($urandom_range(99) < 80) begin
            it.arg2 = 8'd0;
            it.arg3 = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            unique case (op)
               rgbcc_pkg::OP_TEST0, rgbcc_pkg::OP_TEST1: it.arg1 = it.arg3;
               rgbcc_pkg::OP_VOLUME: it.arg1 = 8'($urandom_range(4));
               rgbcc_pkg::OP_MODE: it.arg1 = 8'($urandom_range(2));
               rgbcc_pkg::OP_DUTY:
                  it.arg1 = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(110));
               default: ;
            endcase
         end
      end
      return it;
   endfunction

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++) send(random_item());
   endtask

   // long fade sweep so the current levels reach the wheel's end colors
   task automatic wheel_sweep;
      for (int i = 0; i < 2; i++)
         send(make_item(rgbcc_pkg::FUNC_DIAL, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0));
      for (int i = 0; i < 256; i++)
         send(make_item(rgbcc_pkg::FUNC_TICK, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0));
      for (int i = 0; i < 14; i++)
         send(make_item(rgbcc_pkg::FUNC_DIAL, 1'($urandom_range(1)), 8'd0, 8'd0, 8'd0, 8'd0));
   endtask

   lamp_row_type directed[$];

   function automatic lamp_result_type quiet_result(input logic chime, input logic [1:0] vol,
                                                    input logic vupd);
      lamp_result_type r;
      r = '0;
      r.duty = rgbcc_pkg::DUTY_RESET; r.period = rgbcc_pkg::PERIOD_RESET;
      r.mode = rgbcc_pkg::MODE_COLOR;
      r.chime = chime; r.volume = vol; r.vol_upd = vupd;
      return r;
   endfunction

   task automatic add_row(input lamp_item_type it, input logic known,
                          input lamp_result_type r);
      lamp_row_type row;
      row.item = it; row.known = known; row.result = r;
      directed.push_back(row);
   endtask

   initial begin
      lp_step = 8'd5; lp_upper = 8'd250; lp_lower = 8'd5; lp_hold = 8'd10;
      lp_tgt_r = 8'd0; lp_tgt_g = 8'd0; lp_tgt_b = 8'd0;
      lp_cur_r = 8'd0; lp_cur_g = 8'd0; lp_cur_b = 8'd0;
      lp_phase = 3'd0; lp_hold_cnt = 8'd0; lp_mode = rgbcc_pkg::MODE_COLOR; lp_volume = 2'd0;
      lp_duty = rgbcc_pkg::DUTY_RESET; lp_color_duty = rgbcc_pkg::DUTY_RESET;
      lp_night_duty = rgbcc_pkg::DUTY_RESET;
      lp_period = rgbcc_pkg::PERIOD_RESET; lp_last_hdr = 8'hFF;

      // fixed rows first (reset state, chimes, dropped repeat, volume), then predicted rows
      add_row(make_item(rgbcc_pkg::FUNC_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
              quiet_result(1'b0, 2'd0, 1'b0));
      add_row(make_item(rgbcc_pkg::FUNC_KEY, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
              quiet_result(1'b1, 2'd0, 1'b0));
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'h1, rgbcc_pkg::OP_TEST0},
                        8'd0, 8'd0, 8'd0), 1'b1, quiet_result(1'b1, 2'd0, 1'b0));
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'h1, rgbcc_pkg::OP_TEST1},
                        8'hFF, 8'd0, 8'hFF), 1'b1, quiet_result(1'b0, 2'd0, 1'b0));
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'h2, rgbcc_pkg::OP_VOLUME},
                        8'd1, 8'd0, 8'd0), 1'b1, quiet_result(1'b0, 2'd2, 1'b1));
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'h3, rgbcc_pkg::OP_VOLUME},
                        8'd0, 8'd0, 8'hFF), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'h4, rgbcc_pkg::OP_DUTY},
                        8'd50, 8'd0, 8'd0), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'h5, rgbcc_pkg::OP_DUTY},
                        8'd0, 8'd0, 8'hFF), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'h6, rgbcc_pkg::OP_DUTY},
                        8'd101, 8'd0, 8'd0), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'h7, rgbcc_pkg::OP_MODE},
                        8'd1, 8'd0, 8'd0), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'h8, rgbcc_pkg::OP_DUTY},
                        8'd1, 8'd0, 8'd0), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'h9, rgbcc_pkg::OP_MODE},
                        8'd2, 8'd0, 8'd0), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'hA, rgbcc_pkg::OP_MODE},
                        8'd0, 8'd0, 8'hFF), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'hB, rgbcc_pkg::OP_COLOR},
                        8'd255, 8'd0, 8'd255), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'hC, 4'hF},
                        8'h5A, 8'hA5, 8'h3C), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'hD, rgbcc_pkg::OP_DUTY},
                        8'd100, 8'd1, 8'd0), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b0, {4'hE, rgbcc_pkg::OP_VOLUME},
                        8'd3, 8'd0, 8'h7F), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_DIAL, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_DIAL, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_TICK, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b1, {4'hF, rgbcc_pkg::OP_COLOR},
                        8'd0, 8'd255, 8'd0), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_RF, 1'b1, {4'h0, rgbcc_pkg::OP_DUTY},
                        8'd100, 8'd0, 8'd0), 1'b0, '0);
      add_row(make_item(rgbcc_pkg::FUNC_TICK, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase: reset settings, no idling, one long receiver hold-off
      foreach (directed[i]) drive_item(directed[i].item, directed[i].known, directed[i].result);
      pressure_req <= 1'b1;
      run_random(60);
      drain();

      // phase: extreme high step, sender idling
      csr_write(rgbcc_pkg::CSR_STEP, 8'd255); csr_write(rgbcc_pkg::CSR_UPPER, 8'd255);
      csr_write(rgbcc_pkg::CSR_LOWER, 8'd0); csr_write(rgbcc_pkg::CSR_HOLD, 8'd1);
      send_idle_pct = 58; recv_stall_pct = 0;
      wheel_sweep();
      run_random(60);
      drain();

      // phase: zero step and hold, receiver stalling
      csr_write(rgbcc_pkg::CSR_STEP, 8'd0); csr_write(rgbcc_pkg::CSR_UPPER, 8'd0);
      csr_write(rgbcc_pkg::CSR_LOWER, 8'd255); csr_write(rgbcc_pkg::CSR_HOLD, 8'd0);
      send_idle_pct = 0; recv_stall_pct = 58;
      run_random(90);
      drain();

      // phase: random mid settings, both sides idling
      csr_write(rgbcc_pkg::CSR_STEP, 8'($urandom_range(60, 1)));
      csr_write(rgbcc_pkg::CSR_UPPER, 8'($urandom_range(255, 190)));
      csr_write(rgbcc_pkg::CSR_LOWER, 8'($urandom_range(60, 0)));
      csr_write(rgbcc_pkg::CSR_HOLD, 8'($urandom_range(5, 1)));
      send_idle_pct = 34; recv_stall_pct = 34;
      run_random(90);
      drain();

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
